### src/sha256_pkg.sv
// sha256_pkg: shared types, constants and the rotate function for the SHA-256 hasher.
// No dependencies; imported by the round unit, the message window and the top.
`timescale 1ns / 1ps

package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef word_t hash_t [8];

  localparam int HASH_WORDS  = 8;
  localparam int BLOCK_BYTES = 64;
  localparam int WIN_WORDS   = 16;
  localparam int ROUNDS      = 64;
  localparam int LEN_POS     = 56;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // initial chaining value
  localparam hash_t H_INIT = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // round constants
  localparam word_t K_TAB [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // control from the sequencer to the message window
  typedef struct packed {
    logic       push_byte;
    logic       push_word;
    logic [7:0] data;
  } msg_ctl_t;

  // rotate right by a constant amount
  function automatic word_t ror32(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### src/sha256_if.sv
// sha256_in_if / sha256_out_if: valid/ready channels for message beats and digest beats.
// No dependencies.
`timescale 1ns / 1ps

interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, digest_word, word_index, last, input ready);
  modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface

### src/sha256_message_hasher.sv
// sha256_message_hasher: top level, sequencer, chaining state and byte counter.
// Depends on sha256_pkg, sha256_if, sha256_msg and sha256_round.
//
//   channel  dir  handshake            payload
//   in_chan  in   valid/ready          kind, data_byte
//   out_chan out  valid/ready          digest_word, word_index, last
//
// A message byte is absorbed on acceptance; after the 64th of a block the
// single round unit runs 64 rounds plus one chaining add before input resumes.
// Finish: padding bytes go in one per cycle (64 - fill), then one or two blocks
// are compressed, then eight digest beats, stalled by out_chan.ready as needed.
// in_chan.ready is high only while idle. Reset (rst_n low, synchronous) loads
// the initial hash and clears the byte count.
`timescale 1ns / 1ps

module sha256_message_hasher
  import sha256_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  sha256_in_if.sink    in_chan,
  sha256_out_if.source out_chan
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [60:0]   count_r, count_nxt;
  hash_t         chain_r, chain_nxt;
  hash_t         v_r, v_nxt;
  hash_t         v_round;
  logic [5:0]    rnd_r, rnd_nxt;
  logic [5:0]    pos_r, pos_nxt;
  logic [63:0]   bits_r, bits_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic          first_r, first_nxt;
  logic          len_here_r, len_here_nxt;
  logic          fin_r, fin_nxt;
  msg_ctl_t      msg_ctl;
  word_t         w_cur;
  logic [5:0]    fill;
  logic          in_fire;
  logic          out_fire;
  logic [7:0]    pad_data;
  logic          len_slot;

  sha256_msg u_msg (
    .clk   (clk),
    .ctl   (msg_ctl),
    .w_cur (w_cur)
  );

  sha256_round u_round (
    .v_in  (v_r),
    .k     (K_TAB[rnd_r]),
    .w     (w_cur),
    .v_out (v_round)
  );

  assign fill     = count_r[5:0];
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_chan.valid && out_chan.ready;

  // handshake and output payload
  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = (state_r == ST_OUT);
  assign out_chan.digest_word = chain_r[0];
  assign out_chan.word_index  = idx_r;
  assign out_chan.last        = (idx_r == 3'(HASH_WORDS - 1));

  // padding byte: marker, then zeros, with the bit length in the last 8 slots
  assign len_slot = len_here_r && !first_r && (pos_r >= 6'(LEN_POS));
  assign pad_data = first_r ? PAD_BYTE : (len_slot ? bits_r[63:56] : 8'h00);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    chain_nxt    = chain_r;
    v_nxt        = v_r;
    rnd_nxt      = rnd_r;
    pos_nxt      = pos_r;
    bits_nxt     = bits_r;
    idx_nxt      = idx_r;
    first_nxt    = first_r;
    len_here_nxt = len_here_r;
    fin_nxt      = fin_r;
    msg_ctl      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!in_chan.kind) begin
            // message byte
            msg_ctl.push_byte = 1'b1;
            msg_ctl.data      = in_chan.data_byte;
            count_nxt         = count_r + 61'd1;
            if (fill == 6'(BLOCK_BYTES - 1)) begin
              state_nxt = ST_ROUND;
              v_nxt     = chain_r;
              rnd_nxt   = '0;
            end
          end else begin
            // finish: start padding at the current fill point
            state_nxt    = ST_PAD;
            fin_nxt      = 1'b1;
            first_nxt    = 1'b1;
            pos_nxt      = fill;
            len_here_nxt = (fill < 6'(LEN_POS));
            bits_nxt     = {count_r, 3'b000};
          end
        end
      end

      ST_PAD: begin
        msg_ctl.push_byte = 1'b1;
        msg_ctl.data      = pad_data;
        first_nxt         = 1'b0;
        pos_nxt           = pos_r + 6'd1;
        if (len_slot) begin
          bits_nxt = {bits_r[55:0], 8'h00};
        end
        if (pos_r == 6'(BLOCK_BYTES - 1)) begin
          state_nxt = ST_ROUND;
          v_nxt     = chain_r;
          rnd_nxt   = '0;
        end
      end

      ST_ROUND: begin
        msg_ctl.push_word = 1'b1;
        v_nxt             = v_round;
        rnd_nxt           = rnd_r + 6'd1;
        if (rnd_r == 6'(ROUNDS - 1)) begin
          state_nxt = ST_ADD;
        end
      end

      ST_ADD: begin
        for (int i = 0; i < HASH_WORDS; i++) begin
          chain_nxt[i] = chain_r[i] + v_r[i];
        end
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (len_here_r) begin
          state_nxt = ST_OUT;
          idx_nxt   = '0;
        end else begin
          // extra block: zeros then the length
          state_nxt    = ST_PAD;
          pos_nxt      = '0;
          len_here_nxt = 1'b1;
        end
      end

      ST_OUT: begin
        if (out_fire) begin
          idx_nxt = idx_r + 3'd1;
          for (int i = 0; i < HASH_WORDS - 1; i++) begin
            chain_nxt[i] = chain_r[i + 1];
          end
          chain_nxt[HASH_WORDS - 1] = chain_r[0];
          if (idx_r == 3'(HASH_WORDS - 1)) begin
            state_nxt = ST_IDLE;
            chain_nxt = H_INIT;
            count_nxt = '0;
            fin_nxt   = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      chain_r    <= H_INIT;
      rnd_r      <= '0;
      pos_r      <= '0;
      idx_r      <= '0;
      first_r    <= 1'b0;
      len_here_r <= 1'b0;
      fin_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      chain_r    <= chain_nxt;
      rnd_r      <= rnd_nxt;
      pos_r      <= pos_nxt;
      idx_r      <= idx_nxt;
      first_r    <= first_nxt;
      len_here_r <= len_here_nxt;
      fin_r      <= fin_nxt;
    end
    v_r    <= v_nxt;
    bits_r <= bits_nxt;
  end

endmodule

### src/sha256_msg.sv
// sha256_msg: 16-word message window; bytes shift in, then it runs the schedule.
// Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_msg
  import sha256_pkg::*;
(
  input  logic     clk,
  input  msg_ctl_t ctl,
  output word_t    w_cur
);

  word_t win_r   [WIN_WORDS];
  word_t win_nxt [WIN_WORDS];
  word_t s0;
  word_t s1;
  word_t w_new;

  // schedule: w[t+16] from the window w[t..t+15]
  assign s0    = ror32(win_r[1], 7) ^ ror32(win_r[1], 18) ^ (win_r[1] >> 3);
  assign s1    = ror32(win_r[14], 17) ^ ror32(win_r[14], 19) ^ (win_r[14] >> 10);
  assign w_new = win_r[0] + s0 + win_r[9] + s1;
  assign w_cur = win_r[0];

  // byte shift fills the block big-endian; word shift advances the schedule
  always_comb begin
    for (int j = 0; j < WIN_WORDS - 1; j++) begin
      if (ctl.push_byte) begin
        win_nxt[j] = {win_r[j][23:0], win_r[j + 1][31:24]};
      end else if (ctl.push_word) begin
        win_nxt[j] = win_r[j + 1];
      end else begin
        win_nxt[j] = win_r[j];
      end
    end
    // newest word takes the incoming byte or the scheduled word
    if (ctl.push_byte) begin
      win_nxt[WIN_WORDS - 1] = {win_r[WIN_WORDS - 1][23:0], ctl.data};
    end else if (ctl.push_word) begin
      win_nxt[WIN_WORDS - 1] = w_new;
    end else begin
      win_nxt[WIN_WORDS - 1] = win_r[WIN_WORDS - 1];
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

### src/sha256_round.sv
// sha256_round: one SHA-256 compression round, shared over all 64 rounds.
// Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_round
  import sha256_pkg::*;
(
  input  hash_t v_in,
  input  word_t k,
  input  word_t w,
  output hash_t v_out
);

  word_t big0, big1, choose, major, t1, t2;

  always_comb begin
    big1   = ror32(v_in[4], 6) ^ ror32(v_in[4], 11) ^ ror32(v_in[4], 25);
    choose = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
    t1     = v_in[7] + big1 + choose + k + w;
    big0   = ror32(v_in[0], 2) ^ ror32(v_in[0], 13) ^ ror32(v_in[0], 22);
    major  = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
    t2     = big0 + major;
    v_out[7] = v_in[6];
    v_out[6] = v_in[5];
    v_out[5] = v_in[4];
    v_out[4] = v_in[3] + t1;
    v_out[3] = v_in[2];
    v_out[2] = v_in[1];
    v_out[1] = v_in[0];
    v_out[0] = t1 + t2;
  end

endmodule

### tb/sha256_message_hasher_test.sv
// sha256_message_hasher_test: self-checking bench for the byte-serial SHA-256 hasher.
// Depends on sha256_if (channel interfaces) and sha256_message_hasher (block under test).
// A local SHA-256 predictor queues the digest beats that each finish beat should produce.
`timescale 1ns / 1ps

module sha256_message_hasher_test;

  localparam int CLK_PERIOD    = 10;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_BEATS  = 320;
  localparam int HOLD_CYCLES   = 600;
  localparam int MAX_REPORTS   = 10;

  localparam logic       KIND_BYTE   = 1'b0;
  localparam logic       KIND_FINISH = 1'b1;
  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam int         LEN_OFFSET  = 56;

  // message lengths that put the finish beat on or near a padding boundary
  localparam int EDGE_LENGTHS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  localparam logic [31:0] IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  typedef enum {RX_STREAM, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  sha256_in_if  in_if ();
  sha256_out_if out_if ();

  sha256_message_hasher i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if.sink),
    .out_chan (out_if.source)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor state
  logic [31:0]  chain_h [8];
  logic [7:0]   block_buf [64];
  logic [60:0]  msg_len;
  digest_beat_t expected_digest [$];

  // bench bookkeeping
  int       errors = 0;
  int       beats_sent;
  int       burst_left;
  bit       offering;
  int       holds_requested = 0;
  int       holds_served = 0;
  int       hold_left = 0;
  int       rx_left = 0;
  rx_mode_t rx_mode = RX_STREAM;
  int       cycle_count;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic void sha_reset();
    int i;
    for (i = 0; i < 8; i++) chain_h[i] = IV_WORDS[i];
    for (i = 0; i < 64; i++) block_buf[i] = 8'h00;
    msg_len = '0;
  endfunction

  // one 64-round compression of block_buf into chain_h
  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, ch, maj, t1, t2;
    int t;
    for (t = 0; t < 16; t++) begin
      w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    end
    for (t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (t = 0; t < 8; t++) v[t] = chain_h[t];
    for (t = 0; t < 64; t++) begin
      s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1  = v[7] + s1 + ch + ROUND_K[t] + w[t];
      s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2  = s0 + maj;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (t = 0; t < 8; t++) chain_h[t] = chain_h[t] + v[t];
  endfunction

  // absorb one accepted input beat; a finish beat queues eight digest beats
  function automatic void sha_absorb(input logic kind, input logic [7:0] data);
    logic [5:0]   fill;
    logic [63:0]  bit_len;
    digest_beat_t beat;
    int i;
    fill = msg_len[5:0];
    if (kind == KIND_BYTE) begin
      block_buf[fill] = data;
      msg_len = msg_len + 61'd1;
      if (fill == 6'd63) sha_compress();
    end else begin
      bit_len = {msg_len, 3'b000};
      for (i = fill; i < 64; i++) block_buf[i] = 8'h00;
      block_buf[fill] = PAD_MARK;
      // no room for the length: spill into an extra block
      if (fill >= LEN_OFFSET) begin
        sha_compress();
        for (i = 0; i < 64; i++) block_buf[i] = 8'h00;
      end
      for (i = 0; i < 8; i++) block_buf[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
      sha_compress();
      for (i = 0; i < 8; i++) begin
        beat.word  = chain_h[i];
        beat.index = 3'(i);
        beat.last  = (i == 7);
        expected_digest.push_back(beat);
      end
      sha_reset();
    end
  endfunction

  // compare one accepted digest beat with the oldest expectation
  function automatic void check_digest_beat();
    digest_beat_t exp_beat;
    if (expected_digest.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("unexpected digest beat: word %h index %0d last %b",
                 out_if.digest_word, out_if.word_index, out_if.last);
      end
    end else begin
      exp_beat = expected_digest.pop_front();
      if (out_if.digest_word !== exp_beat.word || out_if.word_index !== exp_beat.index ||
          out_if.last !== exp_beat.last) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("digest beat differs: expected %h/%0d/%b, got %h/%0d/%b",
                   exp_beat.word, exp_beat.index, exp_beat.last,
                   out_if.digest_word, out_if.word_index, out_if.last);
        end
      end
    end
  endfunction

  // receiver: check accepted beats, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_digest_beat();
    if (holds_served != holds_requested) begin
      holds_served = holds_requested;
      hold_left = HOLD_CYCLES;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 80);
    end else begin
      rx_left--;
    end
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STREAM: out_if.ready <= 1'b1;
        RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:   out_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sha256_message_hasher: mismatch");
    $finish;
  end

  // hold one beat on the input until it is taken
  task automatic offer_beat(input logic kind, input logic [7:0] data);
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.data_byte <= data;
    offering = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sha_absorb(kind, data);
    beats_sent++;
  endtask

  task automatic drop_valid();
    if (offering) begin
      in_if.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // bursts of random length with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        drop_valid();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_digests_drained();
    drop_valid();
    while (expected_digest.size() != 0) @(posedge clk);
  endtask

  task automatic send_message(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      offer_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
      pace_sender();
    end
    offer_beat(KIND_FINISH, 8'($urandom_range(0, 255)));
    pace_sender();
  endtask

  // empty message, back-to-back finish, data byte ignored on finish
  task automatic run_empty_messages();
    offer_beat(KIND_FINISH, 8'h00);
    offer_beat(KIND_FINISH, 8'hff);
    pace_sender();
    wait_digests_drained();
  endtask

  // byte extremes and a short text message
  task automatic run_byte_extremes();
    offer_beat(KIND_BYTE, 8'h00);
    offer_beat(KIND_BYTE, 8'hff);
    offer_beat(KIND_FINISH, 8'h5a);
    pace_sender();
    offer_beat(KIND_BYTE, 8'h61);
    offer_beat(KIND_BYTE, 8'h62);
    offer_beat(KIND_BYTE, 8'h63);
    offer_beat(KIND_FINISH, 8'h00);
    pace_sender();
    offer_beat(KIND_BYTE, PAD_MARK);
    offer_beat(KIND_FINISH, 8'ha5);
    wait_digests_drained();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic run_output_holdoff();
    holds_requested++;
    send_message(5);
    send_message(0);
    send_message(3);
    wait_digests_drained();
  endtask

  task automatic run_random_messages();
    int start;
    int len;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      case ($urandom_range(0, 7))
        0:       len = $urandom_range(0, 3);
        1, 2:    len = EDGE_LENGTHS[$urandom_range(0, 9)];
        3:       len = $urandom_range(100, 140);
        default: len = $urandom_range(1, 60);
      endcase
      send_message(len);
      if ($urandom_range(0, 3) == 0) wait_digests_drained();
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.kind      <= KIND_BYTE;
    in_if.data_byte <= 8'h00;
    beats_sent   = 0;
    burst_left   = 0;
    offering     = 1'b0;
    sha_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_empty_messages();
    run_byte_extremes();
    run_output_holdoff();
    run_random_messages();

    wait_digests_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_digest.size() == 0) begin
      $display("sha256_message_hasher: match");
    end else begin
      $display("sha256_message_hasher: mismatch");
    end
    $finish;
  end

endmodule
